// ===== design/twb_pkg.sv =====
// Shared package for the time-window buffer: operation codes, register
// indexes, default depths and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package twb_pkg;

    localparam int DEF_WINDOW_DEPTH  = 64;
    localparam int DEF_EXPIRED_DEPTH = 32;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 32;

    localparam logic [CFG_AW-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_AW-1:0] REG_EVICT_MULT  = 2'd1;

    localparam logic [2:0] KIND_INSERT  = 3'd0;
    localparam logic [2:0] KIND_EVICT   = 3'd1;
    localparam logic [2:0] KIND_LOOKUP  = 3'd2;
    localparam logic [2:0] KIND_FLUSH   = 3'd3;
    localparam logic [2:0] KIND_OBSERVE = 3'd4;
    localparam logic [2:0] KIND_SAFE    = 3'd5;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;     // capture the input transaction
        logic ins_wr;    // append a record to the window
        logic mul;       // register the slack product
        logic thr;       // register the eviction threshold
        logic head_rd;   // read the window head record
        logic pop;       // drop the head record, keep its uid as the key
        logic idx_clr;   // restart a scan and clear the hit flags
        logic xrd;       // read the expired set at the scan index
        logic cmp_x;     // compare expired read data with the key
        logic wrd;       // read the window at head plus scan index
        logic cmp_w;     // compare window read data with the key
        logic idx_inc;   // step the scan index
        logic append;    // add the key to the expired set
        logic fl_start;  // snapshot and clear the expired fill
        logic obs;       // raise the max-seen timestamp
        logic emit;      // load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] kind;
        logic       fill_zero;
        logic       below;
        logic       x_done;
        logic       w_done;
        logic       hit_x;
        logic       fl_empty;
        logic       fl_last;
        logic       out_free;
    } t_sts;

endpackage

// ===== design/timestamp_window_buffer_with_expiry_core.sv =====
// Top level of the time-window buffer with expiry: twb_ctrl and twb_dp, using twb_pkg.
// Each accepted input is dispatched by kind: insert, observe, safe-evict and unused kinds go
// straight to the result; lookup scans the expired set and then the window; flush emits one
// result per uid (one when empty); evict scans the expired set for each popped record.
// One transaction is worked on at a time; the scans through the memories set the rate.
// Reset is synchronous, active low, and empties the window and expired set.
`timescale 1ns / 1ps

module timestamp_window_buffer_with_expiry_core #(
    parameter int WINDOW_DEPTH  = twb_pkg::DEF_WINDOW_DEPTH,
    parameter int EXPIRED_DEPTH = twb_pkg::DEF_EXPIRED_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [twb_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [twb_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [2:0]                 i_kind,
    input  logic [63:0]                i_uid,
    input  logic signed [63:0]         i_stamp,
    input  logic signed [63:0]         i_other_max,
    input  logic                       i_other_present,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_ok,
    output logic                       o_found,
    output logic                       o_is_expired,
    output logic [63:0]                o_uid_out,
    output logic                       o_has_uid,
    output logic signed [63:0]         o_time_out,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]  o_window_count,
    output logic [$clog2(EXPIRED_DEPTH+1)-1:0] o_expired_count,
    output logic                       o_last
);

    // The controller sequences each transaction; every scan reads one memory
    // entry and compares it in the following cycle. The datapath owns all
    // storage, including the output register, so a result can wait for the
    // consumer while the controller returns to idle and takes the next input.
    twb_pkg::t_cmd cmd;
    twb_pkg::t_sts sts;

    twb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Records live in two 64-bit memories addressed as a ring from the head;
    // expired uids fill their memory in arrival order and a flush empties it
    // by clearing the fill count alone.
    twb_dp #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .EXPIRED_DEPTH (EXPIRED_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_kind          (i_kind),
        .i_uid           (i_uid),
        .i_stamp         (i_stamp),
        .i_other_max     (i_other_max),
        .i_other_present (i_other_present),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_ok            (o_ok),
        .o_found         (o_found),
        .o_is_expired    (o_is_expired),
        .o_uid_out       (o_uid_out),
        .o_has_uid       (o_has_uid),
        .o_time_out      (o_time_out),
        .o_window_count  (o_window_count),
        .o_expired_count (o_expired_count),
        .o_last          (o_last)
    );

endmodule

// ===== design/twb_ctrl.sv =====
// Controller state machine of the time-window buffer.
// Depends on twb_pkg for the command and status types and the operation codes.
`timescale 1ns / 1ps

module twb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  twb_pkg::t_sts i_sts,
    output twb_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_EV_THR  = 4'd2;
    localparam logic [3:0] S_EV_HEAD = 4'd3;
    localparam logic [3:0] S_EV_TEST = 4'd4;
    localparam logic [3:0] S_EV_XRD  = 4'd5;
    localparam logic [3:0] S_EV_XCMP = 4'd6;
    localparam logic [3:0] S_EV_APP  = 4'd7;
    localparam logic [3:0] S_LK_XRD  = 4'd8;
    localparam logic [3:0] S_LK_XCMP = 4'd9;
    localparam logic [3:0] S_LK_WRD  = 4'd10;
    localparam logic [3:0] S_LK_WCMP = 4'd11;
    localparam logic [3:0] S_FL_CHK  = 4'd12;
    localparam logic [3:0] S_FL_RD   = 4'd13;
    localparam logic [3:0] S_FL_EMIT = 4'd14;
    localparam logic [3:0] S_EMIT    = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                priority case (i_sts.kind)
                    twb_pkg::KIND_INSERT: begin
                        o_cmd.ins_wr = 1'b1;
                        n_state      = S_EMIT;
                    end
                    twb_pkg::KIND_EVICT: begin
                        o_cmd.mul = 1'b1;
                        n_state   = S_EV_THR;
                    end
                    twb_pkg::KIND_LOOKUP: begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_LK_XRD;
                    end
                    twb_pkg::KIND_FLUSH: begin
                        o_cmd.fl_start = 1'b1;
                        n_state        = S_FL_CHK;
                    end
                    twb_pkg::KIND_OBSERVE: begin
                        o_cmd.obs = 1'b1;
                        n_state   = S_EMIT;
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            S_EV_THR: begin
                o_cmd.thr = 1'b1;
                n_state   = S_EV_HEAD;
            end
            S_EV_HEAD: begin
                if (i_sts.fill_zero) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.head_rd = 1'b1;
                    n_state       = S_EV_TEST;
                end
            end
            S_EV_TEST: begin
                if (i_sts.below) begin
                    o_cmd.pop     = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_EV_XRD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EV_XRD: begin
                if (i_sts.x_done || i_sts.hit_x) begin
                    n_state = S_EV_APP;
                end else begin
                    o_cmd.xrd = 1'b1;
                    n_state   = S_EV_XCMP;
                end
            end
            S_EV_XCMP: begin
                o_cmd.cmp_x   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_EV_XRD;
            end
            S_EV_APP: begin
                o_cmd.append = 1'b1;
                n_state      = S_EV_HEAD;
            end
            S_LK_XRD: begin
                if (i_sts.hit_x) begin
                    n_state = S_EMIT;
                end else if (i_sts.x_done) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_LK_WRD;
                end else begin
                    o_cmd.xrd = 1'b1;
                    n_state   = S_LK_XCMP;
                end
            end
            S_LK_XCMP: begin
                o_cmd.cmp_x   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_LK_XRD;
            end
            S_LK_WRD: begin
                if (i_sts.w_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.wrd = 1'b1;
                    n_state   = S_LK_WCMP;
                end
            end
            S_LK_WCMP: begin
                o_cmd.cmp_w   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_LK_WRD;
            end
            S_FL_CHK: begin
                n_state = i_sts.fl_empty ? S_EMIT : S_FL_RD;
            end
            S_FL_RD: begin
                o_cmd.xrd = 1'b1;
                n_state   = S_FL_EMIT;
            end
            S_FL_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = i_sts.fl_last ? S_IDLE : S_FL_RD;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/twb_dp.sv =====
// Datapath of the time-window buffer: configuration, window and expired-set
// memories, scan index, threshold arithmetic and the output register.
// Depends on twb_pkg.
`timescale 1ns / 1ps

module twb_dp #(
    parameter int WINDOW_DEPTH  = twb_pkg::DEF_WINDOW_DEPTH,
    parameter int EXPIRED_DEPTH = twb_pkg::DEF_EXPIRED_DEPTH,
    localparam int WAW = $clog2(WINDOW_DEPTH),
    localparam int XAW = (EXPIRED_DEPTH > 1) ? $clog2(EXPIRED_DEPTH) : 1,
    localparam int WCW = $clog2(WINDOW_DEPTH + 1),
    localparam int XCW = $clog2(EXPIRED_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [twb_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [twb_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic [2:0]                i_kind,
    input  logic [63:0]               i_uid,
    input  logic signed [63:0]        i_stamp,
    input  logic signed [63:0]        i_other_max,
    input  logic                      i_other_present,
    input  twb_pkg::t_cmd             i_cmd,
    output twb_pkg::t_sts             o_sts,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic                      o_ok,
    output logic                      o_found,
    output logic                      o_is_expired,
    output logic [63:0]               o_uid_out,
    output logic                      o_has_uid,
    output logic signed [63:0]        o_time_out,
    output logic [WCW-1:0]            o_window_count,
    output logic [XCW-1:0]            o_expired_count,
    output logic                      o_last
);

    localparam int IW = (WCW > XCW) ? WCW : XCW;

    // Configuration.
    logic [31:0] r_wsize;
    logic [15:0] r_mult;

    // Latched transaction.
    logic [2:0]  r_kind;
    logic [63:0] r_key;
    logic [63:0] r_stamp;
    logic [63:0] r_omax;
    logic        r_opres;

    // Control state.
    logic [WAW-1:0] r_head;
    logic [WCW-1:0] r_fill;
    logic [XCW-1:0] r_xfill;
    logic [XCW-1:0] r_xbound;
    logic [63:0]    r_max;
    logic [IW-1:0]  r_idx;
    logic           r_hit_x;
    logic           r_hit_w;
    logic           r_ok;

    // Arithmetic.
    logic [47:0] r_prod;
    logic [63:0] r_thr;

    // Memories and their read registers.
    logic [63:0] r_wuid_mem [WINDOW_DEPTH];
    logic [63:0] r_wst_mem  [WINDOW_DEPTH];
    logic [63:0] r_xuid_mem [EXPIRED_DEPTH];
    logic [63:0] r_wuid_q;
    logic [63:0] r_wst_q;
    logic [63:0] r_xuid_q;

    // Output register.
    logic           r_out_valid;
    logic           r_o_ok;
    logic           r_o_found;
    logic           r_o_exp;
    logic [63:0]    r_o_uid;
    logic           r_o_has;
    logic [63:0]    r_o_time;
    logic [WCW-1:0] r_o_wcnt;
    logic [XCW-1:0] r_o_xcnt;
    logic           r_o_last;

    function automatic logic [WAW-1:0] wrap_add(input logic [WAW-1:0] a,
                                               input logic [WAW:0] b);
        logic [WAW:0] s;
        s = {1'b0, a} + b;
        if (s >= (WAW+1)'(WINDOW_DEPTH)) begin
            s = s - (WAW+1)'(WINDOW_DEPTH);
        end
        return s[WAW-1:0];
    endfunction

    logic [WAW-1:0] ins_addr;
    logic [WAW-1:0] rd_addr;
    logic [WAW-1:0] head_nxt;
    logic [64:0]    stamp_b;
    logic [63:0]    slack;
    logic           out_free;
    logic           fl_item;
    logic           fl_last;
    logic [63:0]    safe_t;

    assign ins_addr = wrap_add(r_head, (WAW+1)'(r_fill));
    assign rd_addr  = i_cmd.wrd ? wrap_add(r_head, {1'b0, r_idx[WAW-1:0]}) : r_head;
    assign head_nxt = wrap_add(r_head, (WAW+1)'(1));
    assign slack    = {24'd0, r_prod[47:8]};
    assign stamp_b  = {1'b0, r_stamp ^ twb_pkg::SIGN_BIT};
    assign out_free = !r_out_valid || i_out_ready;
    assign fl_item  = (r_kind == twb_pkg::KIND_FLUSH) && (r_xbound != '0);
    assign fl_last  = ((r_idx + IW'(1)) == IW'(r_xbound));

    // A side sitting at the most negative value has seen nothing and is ignored.
    always_comb begin
        if (!r_opres) begin
            safe_t = r_max;
        end else if (r_max == twb_pkg::SIGN_BIT) begin
            safe_t = r_omax;
        end else if (r_omax == twb_pkg::SIGN_BIT) begin
            safe_t = r_max;
        end else begin
            safe_t = ($signed(r_omax) < $signed(r_max)) ? r_omax : r_max;
        end
    end

    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.fill_zero = (r_fill == '0);
        o_sts.below     = ((r_wst_q ^ twb_pkg::SIGN_BIT) < r_thr);
        o_sts.x_done    = (r_idx >= IW'(r_xbound));
        o_sts.w_done    = (r_idx >= IW'(r_fill));
        o_sts.hit_x     = r_hit_x;
        o_sts.fl_empty  = (r_xbound == '0);
        o_sts.fl_last   = fl_last;
        o_sts.out_free  = out_free;
    end

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= 32'd1000;
            r_mult  <= 16'd256;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == twb_pkg::REG_WINDOW_SIZE) begin
                r_wsize <= i_cfg_wdata;
            end else if (i_cfg_addr == twb_pkg::REG_EVICT_MULT) begin
                r_mult <= i_cfg_wdata[15:0];
            end
        end
    end

    // Latched transaction and arithmetic; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind  <= i_kind;
            r_key   <= i_uid;
            r_stamp <= i_stamp;
            r_omax  <= i_other_max;
            r_opres <= i_other_present;
        end else if (i_cmd.pop) begin
            r_key <= r_wuid_q;
        end
        if (i_cmd.mul) begin
            r_prod <= {32'd0, r_mult} * {16'd0, r_wsize};
        end
        // Biased threshold saturates at zero, below which nothing lies.
        if (i_cmd.thr) begin
            r_thr <= (stamp_b >= {1'b0, slack}) ? 64'(stamp_b - {1'b0, slack}) : 64'd0;
        end
    end

    // Window, expired set, scan and status flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_fill   <= '0;
            r_xfill  <= '0;
            r_xbound <= '0;
            r_max    <= twb_pkg::SIGN_BIT;
            r_idx    <= '0;
            r_hit_x  <= 1'b0;
            r_hit_w  <= 1'b0;
            r_ok     <= 1'b1;
        end else begin
            if (i_cmd.latch) begin
                r_ok    <= (i_kind <= twb_pkg::KIND_SAFE);
                r_hit_x <= 1'b0;
                r_hit_w <= 1'b0;
            end
            if (i_cmd.ins_wr) begin
                if (r_fill < WCW'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + WCW'(1);
                end else begin
                    r_ok <= 1'b0;
                end
            end
            if (i_cmd.pop) begin
                r_head <= head_nxt;
                r_fill <= r_fill - WCW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx    <= '0;
                r_hit_x  <= 1'b0;
                r_hit_w  <= 1'b0;
                r_xbound <= r_xfill;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.cmp_x && (r_xuid_q == r_key)) begin
                r_hit_x <= 1'b1;
            end
            if (i_cmd.cmp_w && (r_wuid_q == r_key)) begin
                r_hit_w <= 1'b1;
            end
            // A uid already held is not stored twice; a full set drops it.
            if (i_cmd.append && !r_hit_x) begin
                if (r_xfill < XCW'(EXPIRED_DEPTH)) begin
                    r_xfill <= r_xfill + XCW'(1);
                end else begin
                    r_ok <= 1'b0;
                end
            end
            if (i_cmd.fl_start) begin
                r_xbound <= r_xfill;
                r_xfill  <= '0;
                r_idx    <= '0;
            end
            if (i_cmd.obs && ($signed(r_max) < $signed(r_stamp))) begin
                r_max <= r_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr && (r_fill < WCW'(WINDOW_DEPTH))) begin
            r_wuid_mem[ins_addr] <= r_key;
            r_wst_mem[ins_addr]  <= r_stamp;
        end
        if (i_cmd.head_rd || i_cmd.wrd) begin
            r_wuid_q <= r_wuid_mem[rd_addr];
            r_wst_q  <= r_wst_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !r_hit_x && (r_xfill < XCW'(EXPIRED_DEPTH))) begin
            r_xuid_mem[r_xfill[XAW-1:0]] <= r_key;
        end
        if (i_cmd.xrd) begin
            r_xuid_q <= r_xuid_mem[r_idx[XAW-1:0]];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_ok    <= r_ok;
            r_o_found <= (r_kind == twb_pkg::KIND_LOOKUP) && !r_hit_x && r_hit_w;
            r_o_exp   <= (r_kind == twb_pkg::KIND_LOOKUP) && r_hit_x;
            r_o_uid   <= fl_item ? r_xuid_q : 64'd0;
            r_o_has   <= fl_item;
            r_o_time  <= (r_kind == twb_pkg::KIND_SAFE) ? safe_t : r_max;
            r_o_wcnt  <= r_fill;
            r_o_xcnt  <= r_xfill;
            r_o_last  <= fl_item ? fl_last : 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_o_ok;
    assign o_found         = r_o_found;
    assign o_is_expired    = r_o_exp;
    assign o_uid_out       = r_o_uid;
    assign o_has_uid       = r_o_has;
    assign o_time_out      = r_o_time;
    assign o_window_count  = r_o_wcnt;
    assign o_expired_count = r_o_xcnt;
    assign o_last          = r_o_last;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WCW'(WINDOW_DEPTH))
        else $error("window fill beyond depth");
    a_xfill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_xfill <= XCW'(EXPIRED_DEPTH))
        else $error("expired fill beyond depth");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over one not yet taken");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_fill != '0))
        else $error("pop from empty window");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for timestamp_window_buffer_with_expiry_core.
// Drives random and directed transactions through valid/ready and checks every result.
// Depends on twb_pkg and the core module.
`timescale 1ns / 1ps

typedef struct packed {
    logic        ok;
    logic        found;
    logic        is_expired;
    logic [63:0] uid_out;
    logic        has_uid;
    logic [63:0] time_out;
    logic [6:0]  window_count;
    logic [5:0]  expired_count;
    logic        last;
} t_result;

// Holds the window/expired-set model and the queue of expected results.
class twb_window_tracker;
    logic [31:0] win_size;
    logic [15:0] mult_q8;
    logic [63:0] rec_uid[64];
    logic [63:0] rec_stamp[64];
    int          head;
    int          fill;
    logic [63:0] gone_uid[32];
    int          gone_fill;
    logic [63:0] max_seen;
    t_result     pending[$];
    int          mismatches;
    int          results_seen;

    function new();
        win_size     = 32'd1000;
        mult_q8      = 16'd256;
        head         = 0;
        fill         = 0;
        gone_fill    = 0;
        max_seen     = twb_pkg::SIGN_BIT;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    function bit is_gone(logic [63:0] u);
        for (int i = 0; i < gone_fill; i++)
            if (gone_uid[i] == u) return 1;
        return 0;
    endfunction

    function bit is_held(logic [63:0] u);
        for (int i = 0; i < fill; i++)
            if (rec_uid[(head + i) % 64] == u) return 1;
        return 0;
    endfunction

    function void push(logic ok, logic fnd, logic exd, logic [63:0] u, logic has,
                       logic [63:0] t, logic lst);
        t_result r;
        r.ok = ok; r.found = fnd; r.is_expired = exd; r.uid_out = u;
        r.has_uid = has; r.time_out = t; r.window_count = fill[6:0];
        r.expired_count = gone_fill[5:0]; r.last = lst;
        pending.insert(pending.size(), r);
    endfunction

    // Note an accepted input transaction and queue what it must produce.
    function void note_input(logic [2:0] kind, logic [63:0] uid, logic [63:0] stamp,
                             logic [63:0] omax, logic opres);
        logic [63:0] slack, biased, thr, t;
        logic        ok;
        case (kind)
            twb_pkg::KIND_INSERT: begin
                ok = 0;
                if (fill < 64) begin
                    rec_uid[(head + fill) % 64]   = uid;
                    rec_stamp[(head + fill) % 64] = stamp;
                    fill++;
                    ok = 1;
                end
                push(ok, 0, 0, 0, 0, max_seen, 1);
            end
            twb_pkg::KIND_EVICT: begin
                // Truncated Q8.8 slack; the threshold saturates at the minimum.
                slack  = ({48'd0, mult_q8} * {32'd0, win_size}) >> 8;
                biased = stamp ^ twb_pkg::SIGN_BIT;
                thr    = (biased >= slack) ? biased - slack : 64'd0;
                ok     = 1;
                while (fill > 0 && ((rec_stamp[head] ^ twb_pkg::SIGN_BIT) < thr)) begin
                    t    = rec_uid[head];
                    head = (head + 1) % 64;
                    fill--;
                    if (!is_gone(t)) begin
                        if (gone_fill < 32) begin
                            gone_uid[gone_fill] = t;
                            gone_fill++;
                        end else begin
                            ok = 0;
                        end
                    end
                end
                push(ok, 0, 0, 0, 0, max_seen, 1);
            end
            twb_pkg::KIND_LOOKUP: begin
                ok = is_gone(uid);
                push(1, !ok && is_held(uid), ok, 0, 0, max_seen, 1);
            end
            twb_pkg::KIND_FLUSH: begin
                int n;
                n = gone_fill;
                gone_fill = 0;
                if (n == 0) push(1, 0, 0, 0, 0, max_seen, 1);
                for (int i = 0; i < n; i++)
                    push(1, 0, 0, gone_uid[i], 1, max_seen, i + 1 == n);
            end
            twb_pkg::KIND_OBSERVE: begin
                if ($signed(max_seen) < $signed(stamp)) max_seen = stamp;
                push(1, 0, 0, 0, 0, max_seen, 1);
            end
            twb_pkg::KIND_SAFE: begin
                // Partner absent or at the sentinel: the other side stands alone.
                if (!opres) t = max_seen;
                else if (max_seen == twb_pkg::SIGN_BIT) t = omax;
                else if (omax == twb_pkg::SIGN_BIT) t = max_seen;
                else t = ($signed(omax) < $signed(max_seen)) ? omax : max_seen;
                push(1, 0, 0, 0, 0, t, 1);
            end
            default: push(0, 0, 0, 0, 0, max_seen, 1);
        endcase
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(t_result got);
        t_result want;
        results_seen++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result, expected none, got uid_out=%h",
                         got.uid_out);
            return;
        end
        want = pending[0];
        pending.delete(0);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR: result %0d exp ok%b f%b x%b u%h h%b t%h w%0d e%0d l%b,",
                          " got ok%b f%b x%b u%h h%b t%h w%0d e%0d l%b"},
                         results_seen, want.ok, want.found, want.is_expired, want.uid_out,
                         want.has_uid, want.time_out, want.window_count,
                         want.expired_count, want.last, got.ok, got.found,
                         got.is_expired, got.uid_out, got.has_uid, got.time_out,
                         got.window_count, got.expired_count, got.last);
        end
    endfunction
endclass

module testbench;
    localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_kind;
    logic [63:0] i_uid;
    logic [63:0] i_stamp;
    logic [63:0] i_other_max;
    logic        i_other_present;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_ok, o_found, o_is_expired, o_has_uid, o_last;
    logic [63:0] o_uid_out, o_time_out;
    logic [6:0]  o_window_count;
    logic [5:0]  o_expired_count;

    twb_window_tracker tracker;
    int  cycle_count = 0;
    bit  quiet_phase;  // no idling on either side during the closing part
    int  stamp_base;

    timestamp_window_buffer_with_expiry_core dut (.*);

    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Watchdog: the worst case is far below this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver stalls in random bursts except in the closing part.
    initial begin
        i_out_ready = 0;
        forever begin
            @(posedge i_clk);
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 0;
                repeat ($urandom_range(1, 5) - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1;
            end
        end
    end

    // Results are sampled at the edge where valid and ready meet.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_result r;
            r.ok = o_ok; r.found = o_found; r.is_expired = o_is_expired;
            r.uid_out = o_uid_out; r.has_uid = o_has_uid; r.time_out = o_time_out;
            r.window_count = o_window_count; r.expired_count = o_expired_count;
            r.last = o_last;
            tracker.check_result(r);
        end
    end

    // Valid stays high after acceptance until the next call drives it again.
    task automatic send_item(logic [2:0] kind, logic [63:0] uid, logic [63:0] stamp,
                             logic [63:0] omax, logic opres);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1; i_kind <= kind; i_uid <= uid; i_stamp <= stamp;
        i_other_max <= omax; i_other_present <= opres;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_input(kind, uid, stamp, omax, opres);
    endtask

    // Drain every expectation, then let the bench idle.
    task automatic settle();
        i_in_valid <= 0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_addr <= idx; i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == twb_pkg::REG_WINDOW_SIZE) tracker.win_size = val;
        else tracker.mult_q8 = val[15:0];
    endtask

    // Mostly well-formed traffic: increasing stamps, uids from a small pool so that
    // lookups and duplicate expiry hit, plus some full-range noise.
    task automatic random_item();
        logic [2:0]  k;
        logic [63:0] u, s;
        int          sel;
        sel = $urandom_range(0, 99);
        u = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : 64'($urandom_range(0, 40));
        stamp_base += $urandom_range(0, 300);
        s = 64'(stamp_base);
        if (sel < 40) k = twb_pkg::KIND_INSERT;
        else if (sel < 55) begin
            k = twb_pkg::KIND_EVICT;
            s = 64'(stamp_base + $urandom_range(0, 2500));
        end
        else if (sel < 70) k = twb_pkg::KIND_LOOKUP;
        else if (sel < 78) k = twb_pkg::KIND_FLUSH;
        else if (sel < 86) k = twb_pkg::KIND_OBSERVE;
        else if (sel < 95) k = twb_pkg::KIND_SAFE;
        else k = ($urandom_range(0, 1) == 0) ? KIND_UNUSED_LO : KIND_UNUSED_HI;
        if ($urandom_range(0, 9) == 0) s = {$urandom, $urandom};
        send_item(k, u, s, {$urandom, $urandom}, $urandom_range(0, 1));
    endtask

    initial begin
        tracker = new();
        quiet_phase = 0;
        stamp_base = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_addr = 0; i_cfg_wdata = 0;
        i_in_valid = 0; i_kind = 0; i_uid = 0; i_stamp = 0;
        i_other_max = 0; i_other_present = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: sentinel handling before anything is observed.
        send_item(twb_pkg::KIND_SAFE, 0, 0, 64'h1234, 1);
        send_item(twb_pkg::KIND_SAFE, 0, 0, twb_pkg::SIGN_BIT, 1);
        send_item(twb_pkg::KIND_SAFE, 0, 0, 64'h55, 0);
        send_item(twb_pkg::KIND_FLUSH, 0, 0, 0, 0);                       // empty set
        send_item(twb_pkg::KIND_OBSERVE, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
        send_item(twb_pkg::KIND_SAFE, 0, 0, twb_pkg::SIGN_BIT, 1);
        send_item(twb_pkg::KIND_SAFE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1);
        send_item(twb_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, twb_pkg::SIGN_BIT, 0, 0);
        send_item(twb_pkg::KIND_INSERT, 64'd0, 64'd5, 0, 0);
        send_item(twb_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd6, 0, 0);  // repeated uid
        // Current time at the minimum: threshold saturates, nothing goes.
        send_item(twb_pkg::KIND_EVICT, 0, twb_pkg::SIGN_BIT, 0, 0);
        send_item(twb_pkg::KIND_LOOKUP, 64'd0, 0, 0, 0);
        send_item(twb_pkg::KIND_EVICT, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
        send_item(twb_pkg::KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
        send_item(twb_pkg::KIND_LOOKUP, 64'h1, 0, 0, 0);
        send_item(KIND_UNUSED_LO, 0, 0, 0, 0);
        send_item(KIND_UNUSED_HI, 0, 0, 0, 0);
        send_item(twb_pkg::KIND_FLUSH, 0, 0, 0, 0);
        // Fill the window to overflow, then expire past the set capacity.
        for (int i = 0; i < 65; i++)
            send_item(twb_pkg::KIND_INSERT, 64'(100 + i), 64'(i), 0, 0);
        send_item(twb_pkg::KIND_EVICT, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
        send_item(twb_pkg::KIND_FLUSH, 0, 0, 0, 0);
        settle();

        // Random phases over several register settings, extremes included.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(twb_pkg::REG_WINDOW_SIZE, 32'd0);
                    write_reg(twb_pkg::REG_EVICT_MULT, 32'd0);
                end
                1: begin
                    write_reg(twb_pkg::REG_WINDOW_SIZE, 32'hFFFF_FFFF);
                    write_reg(twb_pkg::REG_EVICT_MULT, 32'h0000_FFFF);
                end
                2: begin
                    write_reg(twb_pkg::REG_WINDOW_SIZE, 32'd1000);
                    write_reg(twb_pkg::REG_EVICT_MULT, 32'd384);
                end
                3: begin
                    write_reg(twb_pkg::REG_WINDOW_SIZE, 32'($urandom_range(1, 3000)));
                    write_reg(twb_pkg::REG_EVICT_MULT, 32'($urandom_range(1, 600)));
                end
                default: begin
                    write_reg(twb_pkg::REG_WINDOW_SIZE, 32'd500);
                    write_reg(twb_pkg::REG_EVICT_MULT, 32'd256);
                    quiet_phase = 1;
                end
            endcase
            for (int n = 0; n < 4; n++) random_item();
            send_item(twb_pkg::KIND_FLUSH, 0, 0, 0, 0);
            settle();
        end

        $display("Run covered directed sentinel, saturation, full-window and full-set cases");
        $display("and five short random phases over window and multiplier settings, %0d results.",
                 tracker.results_seen);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
